/* rtl/ssdc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssdc_pkg
// Shared constants and types of the stream suffix distinct count unit.
// ----------------------------------------------------------------------------
package ssdc_pkg;

    localparam int CAPACITY_DEF   = 1024;
    localparam int VALUE_BITS_DEF = 32;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_QRY_RD,
        ST_QRY_ACC,
        ST_RESULT,
        ST_CLEAR
    } state_t;

endpackage

/* rtl/stream_suffix_distinct_count_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_suffix_distinct_count_unit
// Counts distinct values in a suffix of a growing stream, using a value
// table and a range-sum tree of superseded positions held in memories.
// ----------------------------------------------------------------------------
// Channel | Direction | Content
// s_axis  | in        | tdata: item_value, left_pos; tuser: op
// m_axis  | out       | tdata: distinct_count; tuser: bad_query
//
// An append scans the value table entry by entry, reading an entry in
// ST_SCAN_RD and comparing it in ST_SCAN_CHK; when the value repeats, the
// tree is then updated level by level (ST_MARK_RD, ST_MARK_WR). A query walks
// the tree level by level, reading in ST_QRY_RD and adding in ST_QRY_ACC.
// After reset a clearing pass zeroes all 2*CAPACITY tree nodes; no item
// is taken during it. One item is processed at a time; a stalled result holds.
module stream_suffix_distinct_count_unit #(
    parameter int CAPACITY   = ssdc_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = ssdc_pkg::VALUE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // item_value[31:0], left_pos[42:32], zero
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // distinct_count[10:0], zero
    output logic        m_axis_tuser    // bad_query
);
    localparam int AW = $clog2(CAPACITY);
    localparam int TW = AW + 1;
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;

    logic [VW-1:0] val_mem [CAPACITY];
    logic [PW-1:0] pos_mem [CAPACITY];
    logic [PW-1:0] tree_mem [2*CAPACITY];

    ssdc_pkg::state_t state_reg, state_next;
    logic [PW-1:0] len_reg, len_next;
    logic [PW-1:0] used_reg, used_next;
    logic [PW-1:0] k_reg, k_next;
    logic [TW:0]   a_reg, a_next, b_reg, b_next;
    logic [TW-1:0] node_reg, node_next;
    logic [PW-1:0] acc_reg, acc_next;
    logic [VW-1:0] v_reg, v_next;
    logic [PW-1:0] l_reg, l_next;
    logic          side_reg, side_next;
    logic [10:0]   cnt_reg, cnt_next;
    logic          bad_reg, bad_next;
    logic [TW:0]   clr_reg, clr_next;

    logic [VW-1:0] val_rd;
    logic [PW-1:0] pos_rd, tree_rd;
    logic          tab_we, pos_we, tree_we;
    logic [AW-1:0] tab_addr;
    logic [PW-1:0] pos_wd, tree_wd;
    logic [TW-1:0] tree_addr;

    always_ff @(posedge aclk) begin
        if (tab_we) val_mem[tab_addr] <= v_reg;
        if (pos_we) pos_mem[tab_addr] <= pos_wd;
        val_rd <= val_mem[tab_addr];
        pos_rd <= pos_mem[tab_addr];
        if (tree_we) tree_mem[tree_addr] <= tree_wd;
        tree_rd <= tree_mem[tree_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ssdc_pkg::ST_CLEAR;
            len_reg   <= '0;
            used_reg  <= '0;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            used_reg  <= used_next;
            clr_reg   <= clr_next;
        end
        k_reg <= k_next; a_reg <= a_next; b_reg <= b_next; node_reg <= node_next;
        acc_reg <= acc_next; v_reg <= v_next; l_reg <= l_next; side_reg <= side_next;
        cnt_reg <= cnt_next; bad_reg <= bad_next;
    end

    // Next state and datapath.
    always_comb begin
        logic [PW-1:0] lp;
        lp = s_axis_tdata[32 +: PW];
        state_next = state_reg;
        len_next = len_reg; used_next = used_reg; k_next = k_reg;
        a_next = a_reg; b_next = b_reg; node_next = node_reg; acc_next = acc_reg;
        v_next = v_reg; l_next = l_reg; side_next = side_reg;
        cnt_next = cnt_reg; bad_next = bad_reg; clr_next = clr_reg;
        unique case (state_reg)
            ssdc_pkg::ST_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (TW+1)'(2*CAPACITY - 1)) state_next = ssdc_pkg::ST_IDLE;
            end
            ssdc_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    v_next = s_axis_tdata[VW-1:0];
                    l_next = lp;
                    k_next = '0;
                    if (s_axis_tuser == ssdc_pkg::OP_QUERY) begin
                        if (lp == '0 || lp > len_reg ||
                            s_axis_tdata[42:32] > 11'(CAPACITY)) begin
                            cnt_next = '0; bad_next = 1'b1;
                            state_next = ssdc_pkg::ST_RESULT;
                        end else begin
                            a_next = (TW+1)'(CAPACITY) + (TW+1)'(lp) - 1'b1;
                            b_next = (TW+1)'(CAPACITY) + (TW+1)'(len_reg);
                            acc_next = '0; side_next = 1'b0; bad_next = 1'b0;
                            state_next = ssdc_pkg::ST_QRY_RD;
                        end
                    end else if (len_reg < PW'(CAPACITY)) begin
                        state_next = ssdc_pkg::ST_SCAN_RD;
                    end
                end
            end
            ssdc_pkg::ST_SCAN_RD: begin
                if (k_reg >= used_reg) begin
                    if (used_reg < PW'(CAPACITY)) used_next = used_reg + 1'b1;
                    len_next = len_reg + 1'b1;
                    state_next = ssdc_pkg::ST_IDLE;
                end else state_next = ssdc_pkg::ST_SCAN_CHK;
            end
            ssdc_pkg::ST_SCAN_CHK: begin
                if (val_rd == v_reg) begin
                    len_next = len_reg + 1'b1;
                    node_next = TW'(CAPACITY) + TW'(pos_rd) - 1'b1;
                    state_next = ssdc_pkg::ST_MARK_RD;
                end else begin
                    k_next = k_reg + 1'b1;
                    state_next = ssdc_pkg::ST_SCAN_RD;
                end
            end
            ssdc_pkg::ST_MARK_RD: state_next = ssdc_pkg::ST_MARK_WR;
            ssdc_pkg::ST_MARK_WR: begin
                node_next = node_reg >> 1;
                state_next = (node_reg == TW'(1)) ? ssdc_pkg::ST_IDLE
                                                  : ssdc_pkg::ST_MARK_RD;
            end
            ssdc_pkg::ST_QRY_RD: begin
                if (a_reg >= b_reg) begin
                    cnt_next = 11'(len_reg - l_reg + 1'b1 - acc_reg);
                    state_next = ssdc_pkg::ST_RESULT;
                end else if (!side_reg && a_reg[0]) begin
                    state_next = ssdc_pkg::ST_QRY_ACC;
                end else if (side_reg && b_reg[0]) begin
                    b_next = b_reg - 1'b1;
                    state_next = ssdc_pkg::ST_QRY_ACC;
                end else if (side_reg) begin
                    a_next = a_reg >> 1; b_next = b_reg >> 1; side_next = 1'b0;
                end else side_next = 1'b1;
            end
            ssdc_pkg::ST_QRY_ACC: begin
                acc_next = acc_reg + tree_rd;
                if (!side_reg) begin
                    a_next = a_reg + 1'b1; side_next = 1'b1;
                end else begin
                    a_next = a_reg >> 1; b_next = b_reg >> 1; side_next = 1'b0;
                end
                state_next = ssdc_pkg::ST_QRY_RD;
            end
            ssdc_pkg::ST_RESULT: if (m_axis_tready) state_next = ssdc_pkg::ST_IDLE;
            default: state_next = ssdc_pkg::ST_IDLE;
        endcase
    end

    // Memory ports and handshake outputs.
    always_comb begin
        tab_addr = k_reg[AW-1:0];
        tab_we = 1'b0; pos_we = 1'b0; pos_wd = len_reg + 1'b1;
        tree_we = 1'b0; tree_wd = tree_rd + 1'b1; tree_addr = node_reg;
        unique case (state_reg)
            ssdc_pkg::ST_CLEAR: begin
                tree_we = 1'b1; tree_wd = '0; tree_addr = clr_reg[TW-1:0];
            end
            ssdc_pkg::ST_SCAN_RD: if (k_reg >= used_reg && used_reg < PW'(CAPACITY)) begin
                tab_addr = used_reg[AW-1:0]; tab_we = 1'b1; pos_we = 1'b1;
            end
            ssdc_pkg::ST_SCAN_CHK: if (val_rd == v_reg) pos_we = 1'b1;
            ssdc_pkg::ST_MARK_WR: tree_we = 1'b1;
            ssdc_pkg::ST_QRY_RD:
                tree_addr = side_reg ? TW'(b_reg - 1'b1) : a_reg[TW-1:0];
            default: ;
        endcase
        s_axis_tready = (state_reg == ssdc_pkg::ST_IDLE);
        m_axis_tvalid = (state_reg == ssdc_pkg::ST_RESULT);
        m_axis_tdata  = {5'b0, cnt_reg};
        m_axis_tuser  = bad_reg;
    end
endmodule

/* rtl/ssdc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssdc_checker
// Port-level checks of the stream suffix distinct count unit.
// ----------------------------------------------------------------------------
module ssdc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    // One item at a time: no input is taken while a result waits.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready with result pending");
    a_badzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata == 16'd0)
        else $error("bad query with non-zero count");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[15:11] == 5'd0) else $error("padding set");
endmodule

bind stream_suffix_distinct_count_unit ssdc_checker u_ssdc_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
);
